[rtl/pwlc_pkg.sv]
// Shared types, constants and arithmetic helpers for the curve lookup block.
package pwlc_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = 4;
	localparam int NUM_W      = 5;
	localparam int DATA_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int TM_W       = PROD_W - FRAC_BITS;
	localparam int WIDE_W     = 50;
	localparam int CNT_W      = $clog2(DATA_W);

	typedef logic [1:0] func_t;

	localparam func_t FUNC_LOAD   = 2'd0;
	localparam func_t FUNC_Y_OF_X = 2'd1;
	localparam func_t FUNC_X_OF_Y = 2'd2;
	localparam func_t FUNC_SLOPE  = 2'd3;

	typedef logic signed [DATA_W-1:0] q16_t;

	localparam q16_t Q16_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam q16_t Q16_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic sat;
		q16_t val;
	} sat_res_t;

	// Point count with zero taken as one and large values clipped to the table depth
	function automatic logic [NUM_W-1:0] active_count(input logic [NUM_W-1:0] num);
		logic [NUM_W-1:0] n;
		n = num;
		if (num == '0) begin
			n = NUM_W'(1);
		end else if (num > NUM_W'(MAX_POINTS)) begin
			n = NUM_W'(MAX_POINTS);
		end
		return n;
	endfunction

	function automatic logic [DATA_W:0] sext_d(input q16_t v);
		return {v[DATA_W-1], v};
	endfunction

	function automatic logic signed [WIDE_W-1:0] sext_w(input q16_t v);
		return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	// Magnitude of a difference of two points; always fits the data width
	function automatic logic [DATA_W-1:0] mag_d(input logic [DATA_W:0] v);
		logic [DATA_W:0] m;
		m = v[DATA_W] ? (~v + 1'b1) : v;
		return m[DATA_W-1:0];
	endfunction

	function automatic sat_res_t sat32(input logic signed [WIDE_W-1:0] v);
		sat_res_t r;
		r.sat = 1'b0;
		r.val = v[DATA_W-1:0];
		if (v[WIDE_W-1:DATA_W-1] != {(WIDE_W-DATA_W+1){v[WIDE_W-1]}}) begin
			r.sat = 1'b1;
			r.val = v[WIDE_W-1] ? Q16_MIN : Q16_MAX;
		end
		return r;
	endfunction

endpackage

[rtl/piecewise_linear_curve_lookup_top.sv]
// Piecewise-linear curve lookup: point table in two memories, scan sequencer and serial divider.
//
//  channel  | signals                                                  | handshake
//  ---------+----------------------------------------------------------+-------------------
//  cfg      | cfg_data (num_points)                                    | cfg_valid/cfg_ready
//  request  | func, point_index, point_x, point_y, query_value         | req_valid/req_stall
//  response | interp_value, slope, intercept, segment, saturated       | rsp_valid/rsp_stall
//
// One transaction is in work at a time. A load goes straight to the finish state. A query
// scans the table, one entry per cycle from the memory read port; a clamped query then
// finishes, and an interpolating or slope query runs the 32-step radix-2 divider unless
// the quotient overflows or the segment is vertical. Reset clears only control state: num_points
// returns to 1 and the table holds nothing until loaded. A result waiting under rsp_stall
// does not block the next request; the block holds only when its own result is ready.
module piecewise_linear_curve_lookup_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pwlc_pkg::NUM_W-1:0]       cfg_data,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  pwlc_pkg::func_t                  func,
	input  logic [pwlc_pkg::IDX_W-1:0]       point_index,
	input  pwlc_pkg::q16_t                   point_x,
	input  pwlc_pkg::q16_t                   point_y,
	input  pwlc_pkg::q16_t                   query_value,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output pwlc_pkg::q16_t                   interp_value,
	output pwlc_pkg::q16_t                   slope,
	output pwlc_pkg::q16_t                   intercept,
	output logic [pwlc_pkg::IDX_W-1:0]       segment,
	output logic                             saturated
);
	import pwlc_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_SCAN = 11'b000_0000_0010,
		S_PREP = 11'b000_0000_0100,
		S_MUL  = 11'b000_0000_1000,
		S_DCHK = 11'b000_0001_0000,
		S_DIV  = 11'b000_0010_0000,
		S_RES  = 11'b000_0100_0000,
		S_IMUL = 11'b000_1000_0000,
		S_IABS = 11'b001_0000_0000,
		S_ISUB = 11'b010_0000_0000,
		S_FIN  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [NUM_W-1:0] num_points_q;
	logic             rsp_valid_q;

	// point table
	q16_t             x_mem [MAX_POINTS];
	q16_t             y_mem [MAX_POINTS];
	q16_t             rd_x_q, rd_y_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;

	// transaction context
	func_t            func_q;
	q16_t             query_q;
	logic [NUM_W-1:0] n_q;
	logic             single_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] seg_q;
	q16_t             prev_x_q, prev_y_q;
	q16_t             base_q;
	q16_t             seg_x_q, seg_y_q;
	logic [DATA_W:0]  ta_q, tb_q, td_q;

	// multiplier and divider
	logic                     neg_q;
	logic [DATA_W-1:0]        d_q;
	logic [DATA_W-1:0]        mcand_q, mplier_q;
	logic [DATA_W-1:0]        rem_q, lo_q;
	logic                     ovf_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [TM_W-1:0]          tm_q;
	logic                     tneg_q;

	// result under construction and output register
	q16_t             res_val_q, res_slope_q, res_icpt_q;
	logic             res_flag_q;
	q16_t             out_val_q, out_slope_q, out_icpt_q;
	logic [IDX_W-1:0] out_seg_q;
	logic             out_flag_q;

	logic             req_accept, rsp_free;
	q16_t             src_rd, dst_rd, src_prev, dst_prev;
	logic             hit, last;
	logic [DATA_W:0]  a_diff, b_diff, d_diff;
	logic [DATA_W-1:0] tb_mag;
	logic [PROD_W-1:0] pdiv, mul_p, pmag;
	logic [DATA_W:0]  div_try, div_rem;
	logic             div_ge;
	logic signed [WIDE_W-1:0] q_wide, lk_sum, sl_val, ic_diff, tm_wide;
	sat_res_t         lk_sat, sl_sat, ic_sat;

	assign cfg_ready  = 1'b1;
	assign req_stall  = (state_q != S_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign wr_en      = req_accept && (func == FUNC_LOAD);

	assign rsp_valid    = rsp_valid_q;
	assign interp_value = out_val_q;
	assign slope        = out_slope_q;
	assign intercept    = out_icpt_q;
	assign segment      = out_seg_q;
	assign saturated    = out_flag_q;

	// the scan reads one entry ahead of the entry it is comparing
	assign rd_addr = (state_q == S_SCAN) ? idx_q + IDX_W'(1) : '0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_mem[point_index] <= point_x;
			y_mem[point_index] <= point_y;
		end
		rd_x_q <= x_mem[rd_addr];
		rd_y_q <= y_mem[rd_addr];
	end

	always_comb begin
		src_rd   = (func_q == FUNC_X_OF_Y) ? rd_y_q : rd_x_q;
		dst_rd   = (func_q == FUNC_X_OF_Y) ? rd_x_q : rd_y_q;
		src_prev = (func_q == FUNC_X_OF_Y) ? prev_y_q : prev_x_q;
		dst_prev = (func_q == FUNC_X_OF_Y) ? prev_x_q : prev_y_q;
		hit      = (query_q <= src_rd);
		last     = ({1'b0, idx_q} == (n_q - NUM_W'(1)));
		a_diff   = sext_d(query_q) - sext_d(src_prev);
		b_diff   = sext_d(dst_rd) - sext_d(dst_prev);
		d_diff   = sext_d(src_rd) - sext_d(src_prev);
		tb_mag   = mag_d(tb_q);
		pdiv     = PROD_W'(tb_mag) << FRAC_BITS;
		mul_p    = mcand_q * mplier_q;
		pmag     = prod_q[PROD_W-1] ? (~prod_q + 1'b1) : prod_q;
		div_try  = {rem_q, lo_q[DATA_W-1]};
		div_ge   = (div_try >= {1'b0, d_q});
		div_rem  = div_try - {1'b0, d_q};
		q_wide   = {{(WIDE_W-DATA_W){1'b0}}, lo_q};
		lk_sum   = neg_q ? (sext_w(base_q) - q_wide) : (sext_w(base_q) + q_wide);
		sl_val   = neg_q ? (WIDE_W'(0) - q_wide) : q_wide;
		tm_wide  = {{(WIDE_W-TM_W){1'b0}}, tm_q};
		ic_diff  = tneg_q ? (sext_w(seg_y_q) + tm_wide) : (sext_w(seg_y_q) - tm_wide);
		lk_sat   = sat32(lk_sum);
		sl_sat   = sat32(sl_val);
		ic_sat   = sat32(ic_diff);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					state_d = (func == FUNC_LOAD) ? S_FIN : S_SCAN;
				end
			end
			S_SCAN: begin
				if (func_q == FUNC_SLOPE) begin
					if (single_q) begin
						state_d = (rd_x_q == '0) ? S_FIN : S_PREP;
					end else if ((idx_q != '0) && (hit || last)) begin
						state_d = S_PREP;
					end
				end else if ((hit && (idx_q == '0)) || (!hit && last)) begin
					state_d = S_FIN;
				end else if (hit) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (func_q != FUNC_SLOPE) begin
					state_d = S_MUL;
				end else if (td_q == '0) begin
					state_d = S_IMUL;
				end else begin
					state_d = S_DCHK;
				end
			end
			S_MUL:  state_d = S_DCHK;
			S_DCHK: state_d = (rem_q >= d_q) ? S_RES : S_DIV;
			S_DIV: begin
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					state_d = S_RES;
				end
			end
			S_RES:  state_d = ((func_q != FUNC_SLOPE) || single_q) ? S_FIN : S_IMUL;
			S_IMUL: state_d = S_IABS;
			S_IABS: state_d = S_ISUB;
			S_ISUB: state_d = S_FIN;
			S_FIN: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			num_points_q <= NUM_W'(1);
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				num_points_q <= cfg_data;
			end
			if ((state_q == S_FIN) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					func_q      <= func;
					query_q     <= query_value;
					n_q         <= active_count(num_points_q);
					single_q    <= (active_count(num_points_q) == NUM_W'(1));
					idx_q       <= '0;
					seg_q       <= '0;
					res_val_q   <= '0;
					res_slope_q <= '0;
					res_icpt_q  <= '0;
					res_flag_q  <= 1'b0;
				end
			end
			S_SCAN: begin
				// every field is rewritten each step (res_val_q only outside slope queries); the values of the final step stand
				prev_x_q <= rd_x_q;
				prev_y_q <= rd_y_q;
				base_q   <= dst_prev;
				seg_x_q  <= rd_x_q;
				seg_y_q  <= rd_y_q;
				idx_q    <= idx_q + IDX_W'(1);
				ta_q     <= a_diff;
				if ((func_q == FUNC_SLOPE) && single_q) begin
					tb_q <= sext_d(rd_y_q);
					td_q <= sext_d(rd_x_q);
				end else begin
					tb_q <= b_diff;
					td_q <= d_diff;
				end
				if (func_q == FUNC_SLOPE) begin
					seg_q <= idx_q;
				end else begin
					seg_q     <= (hit && (idx_q != '0)) ? idx_q : '0;
					res_val_q <= dst_rd;
				end
			end
			S_PREP: begin
				neg_q    <= tb_q[DATA_W] ^ td_q[DATA_W];
				d_q      <= mag_d(td_q);
				mcand_q  <= ta_q[DATA_W-1:0];
				mplier_q <= tb_mag;
				rem_q    <= pdiv[PROD_W-1:DATA_W];
				lo_q     <= pdiv[DATA_W-1:0];
				if ((func_q == FUNC_SLOPE) && (td_q == '0)) begin
					// vertical segment: flag it and saturate by the sign of the rise, or give zero if there is no rise
					res_flag_q <= 1'b1;
					if (tb_q == '0) begin
						res_slope_q <= '0;
					end else begin
						res_slope_q <= tb_q[DATA_W] ? Q16_MIN : Q16_MAX;
					end
				end
			end
			S_MUL: begin
				rem_q <= mul_p[PROD_W-1:DATA_W];
				lo_q  <= mul_p[DATA_W-1:0];
			end
			S_DCHK: begin
				ovf_q <= (rem_q >= d_q);
				cnt_q <= '0;
			end
			S_DIV: begin
				rem_q <= div_ge ? div_rem[DATA_W-1:0] : div_try[DATA_W-1:0];
				lo_q  <= {lo_q[DATA_W-2:0], div_ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			S_RES: begin
				if (func_q != FUNC_SLOPE) begin
					res_val_q  <= lk_sat.val;
					res_flag_q <= res_flag_q | lk_sat.sat;
				end else if (ovf_q) begin
					res_slope_q <= neg_q ? Q16_MIN : Q16_MAX;
					res_flag_q  <= 1'b1;
				end else begin
					res_slope_q <= sl_sat.val;
					res_flag_q  <= res_flag_q | sl_sat.sat;
				end
			end
			S_IMUL: begin
				prod_q <= res_slope_q * seg_x_q;
			end
			S_IABS: begin
				tm_q   <= pmag[PROD_W-1:FRAC_BITS];
				tneg_q <= prod_q[PROD_W-1];
			end
			S_ISUB: begin
				res_icpt_q <= ic_sat.val;
				res_flag_q <= res_flag_q | ic_sat.sat;
			end
			S_FIN: begin
				if (rsp_free) begin
					out_val_q   <= res_val_q;
					out_slope_q <= res_slope_q;
					out_icpt_q  <= res_icpt_q;
					out_seg_q   <= seg_q;
					out_flag_q  <= res_flag_q;
				end
			end
			default: ;
		endcase
	end

	a_fin_posts: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && rsp_free) |=> (rsp_valid_q && (state_q == S_IDLE)))
		else $error("finished transaction not posted to the response register");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ({1'b0, idx_q} < n_q))
		else $error("table scan ran past the last point in use");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < d_q))
		else $error("divider remainder not below divisor");

endmodule
